// ===== rtl/ssp_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Step pulse generator package
// Shared widths, codes and the result record of the step pulse generator.
// ----------------------------------------------------------------------------
package ssp_pkg;

    localparam int HALF_PERIOD_W   = 15;
    localparam int TIMER_W         = 16;
    localparam int STEP_COUNT_W    = 32;
    localparam int POSITION_W      = 32;
    localparam int CFG_INDEX_W     = 1;
    localparam int CFG_DATA_W      = 15;
    localparam int OUT_TDATA_W     = 40;

    localparam logic [HALF_PERIOD_W-1:0] MIN_HALF_PERIOD   = 15'd16;
    localparam logic [HALF_PERIOD_W-1:0] MAX_HALF_PERIOD   = 15'd32767;
    localparam logic [HALF_PERIOD_W-1:0] HALF_PERIOD_RESET = 15'd1000;

    typedef enum logic {
        OP_TICK  = 1'b0,
        OP_START = 1'b1
    } t_op;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_HALF_PERIOD = 1'b0,
        CFG_DIRECTION   = 1'b1
    } t_cfg_idx;

    // Packed from the lowest bit up: step_out, position, ready_res, running
    typedef struct packed {
        logic                         running;
        logic                         ready_res;
        logic signed [POSITION_W-1:0] position;
        logic                         step_out;
    } t_result;

endpackage

// ===== rtl/ssp_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Step pulse generator core
// Holds the period timer, step pin, step counter and position, and updates
// them for each accepted item in a single pass. Also owns the config registers.
// ----------------------------------------------------------------------------
module ssp_core (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_valid,
    input  logic [ssp_pkg::CFG_INDEX_W-1:0]     i_cfg_index,
    input  logic [ssp_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    input  logic                                i_item_valid,
    input  ssp_pkg::t_op                        i_op,
    input  logic [ssp_pkg::STEP_COUNT_W-1:0]    i_step_count,
    output ssp_pkg::t_result                    o_result
);

    logic [ssp_pkg::HALF_PERIOD_W-1:0] r_half;
    logic                              r_dir;
    logic [ssp_pkg::TIMER_W-1:0]       r_timer, n_timer;
    logic                              r_run, n_run;
    logic                              r_level, n_level;
    logic [ssp_pkg::STEP_COUNT_W-1:0]  r_steps, n_steps;
    logic [ssp_pkg::POSITION_W-1:0]    r_coord, n_coord;
    logic                              r_done, n_done;

    logic [ssp_pkg::TIMER_W-1:0]       w_cycle;
    logic [ssp_pkg::TIMER_W:0]         w_next;
    logic [ssp_pkg::TIMER_W-1:0]       w_timer_inc;
    logic [ssp_pkg::HALF_PERIOD_W-1:0] w_half_clamped;

    // Clamp a half period write to its bounds
    always_comb begin
        if (i_cfg_data > ssp_pkg::MAX_HALF_PERIOD) begin
            w_half_clamped = ssp_pkg::MAX_HALF_PERIOD;
        end else if (i_cfg_data < ssp_pkg::MIN_HALF_PERIOD) begin
            w_half_clamped = ssp_pkg::MIN_HALF_PERIOD;
        end else begin
            w_half_clamped = i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_half <= ssp_pkg::HALF_PERIOD_RESET;
            r_dir  <= 1'b0;
        end else if (i_cfg_valid) begin
            case (ssp_pkg::t_cfg_idx'(i_cfg_index))
                ssp_pkg::CFG_HALF_PERIOD: r_half <= w_half_clamped;
                ssp_pkg::CFG_DIRECTION:   r_dir  <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // Timer wraps at twice the half period, also when already past it
    assign w_cycle     = {r_half, 1'b0};
    assign w_next      = {1'b0, r_timer} + {{ssp_pkg::TIMER_W{1'b0}}, 1'b1};
    assign w_timer_inc = (w_next >= {1'b0, w_cycle}) ? '0 : w_next[ssp_pkg::TIMER_W-1:0];

    always_comb begin
        n_timer = r_timer;
        n_run   = r_run;
        n_level = r_level;
        n_steps = r_steps;
        n_coord = r_coord;
        n_done  = r_done;
        if (i_item_valid) begin
            case (i_op)
                ssp_pkg::OP_START: begin
                    n_steps = i_step_count;
                    n_done  = 1'b0;
                    n_run   = 1'b1;
                end
                ssp_pkg::OP_TICK: begin
                    if (r_run) begin
                        n_timer = w_timer_inc;
                        if (w_timer_inc == {1'b0, r_half}) begin
                            if (r_level) begin
                                // drop a high pin, no step taken
                                n_level = 1'b0;
                            end else if (r_steps != '0) begin
                                n_level = 1'b1;
                                n_steps = r_steps
                                        - {{(ssp_pkg::STEP_COUNT_W-1){1'b0}}, 1'b1};
                                n_coord = r_dir
                                        ? (r_coord - {{(ssp_pkg::POSITION_W-1){1'b0}}, 1'b1})
                                        : (r_coord + {{(ssp_pkg::POSITION_W-1){1'b0}}, 1'b1});
                                if (r_steps == {{(ssp_pkg::STEP_COUNT_W-1){1'b0}}, 1'b1}) begin
                                    n_run  = 1'b0;
                                    n_done = 1'b1;
                                end
                            end else begin
                                n_run  = 1'b0;
                                n_done = 1'b1;
                            end
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timer <= '0;
            r_run   <= 1'b0;
            r_level <= 1'b0;
            r_steps <= '0;
            r_coord <= '0;
            r_done  <= 1'b0;
        end else begin
            r_timer <= n_timer;
            r_run   <= n_run;
            r_level <= n_level;
            r_steps <= n_steps;
            r_coord <= n_coord;
            r_done  <= n_done;
        end
    end

    assign o_result.step_out  = n_level;
    assign o_result.position  = n_coord;
    assign o_result.ready_res = n_done;
    assign o_result.running   = n_run;

    a_done_not_running: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> !r_run)
        else $error("ready set while timer running");

    a_rise_moves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && $rose(r_level)) |-> (r_coord != $past(r_coord)))
        else $error("step pin rose without a position change");

    a_move_on_rise: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && (r_coord != $past(r_coord))) |-> (r_level && !$past(r_level)))
        else $error("position changed without a rising step");

endmodule

// ===== rtl/ssp_out_skid.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Step pulse generator output buffer
// Output register plus one skid entry, so a new item is taken while a
// finished result still waits downstream.
// ----------------------------------------------------------------------------
module ssp_out_skid (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  ssp_pkg::t_result  i_data,
    output logic              o_space,
    output logic              o_valid,
    input  logic              i_ready,
    output ssp_pkg::t_result  o_data
);

    logic             r_main_valid;
    logic             r_skid_valid;
    ssp_pkg::t_result r_main;
    ssp_pkg::t_result r_skid;
    logic             w_pop;

    assign w_pop   = r_main_valid && i_ready;
    assign o_space = !r_skid_valid;
    assign o_valid = r_main_valid;
    assign o_data  = r_main;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_main_valid <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (w_pop) begin
            if (r_skid_valid) begin
                r_skid_valid <= 1'b0;
            end else begin
                r_main_valid <= i_push;
            end
        end else if (i_push) begin
            if (!r_main_valid) begin
                r_main_valid <= 1'b1;
            end else begin
                r_skid_valid <= 1'b1;
            end
        end
    end

    // Payload: advance skid into main on pop, otherwise fill the free slot
    always_ff @(posedge i_clk) begin
        if (w_pop) begin
            if (r_skid_valid) begin
                r_main <= r_skid;
            end else if (i_push) begin
                r_main <= i_data;
            end
        end else if (i_push) begin
            if (!r_main_valid) begin
                r_main <= i_data;
            end else begin
                r_skid <= i_data;
            end
        end
    end

    a_skid_behind_main: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_main_valid)
        else $error("skid entry held with empty output register");

endmodule

// ===== rtl/stepper_step_pulse_generator_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Step pulse generator, top level
// Step/dir pulse generator: period timer with compare, step counter and
// signed position, behind stream input and output channels.
//
// Channel   Dir  Handshake                     Payload
// s_axis    in   s_axis_tvalid/s_axis_tready   tuser: operation; tdata: step_count
// m_axis    out  m_axis_tvalid/m_axis_tready   tdata: step_out, position,
//                                              ready_res, running
// cfg       in   i_cfg_valid/o_cfg_ready       i_cfg_index, i_cfg_data
//
// One item per clock while s_axis_tready is high; its result is registered.
// State updates in a single pass from the state registers at acceptance.
// Reset is synchronous, active low; it clears all state and loads the
// default half period. A stalled output fills one skid entry, then
// s_axis_tready drops until the consumer takes a result.
// ----------------------------------------------------------------------------
module stepper_step_pulse_generator_top (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [ssp_pkg::STEP_COUNT_W-1:0]    s_axis_tdata,  // [31:0] step_count
    input  logic                                s_axis_tuser,  // [0] operation
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // [0] step_out, [32:1] position, [33] ready_res, [34] running, [39:35] zero
    output logic [ssp_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [ssp_pkg::CFG_INDEX_W-1:0]     i_cfg_index,
    input  logic [ssp_pkg::CFG_DATA_W-1:0]      i_cfg_data
);

    logic             w_accept;
    logic             w_space;
    ssp_pkg::t_result w_result;
    ssp_pkg::t_result w_out;

    assign s_axis_tready = w_space;
    assign w_accept      = s_axis_tvalid && w_space;
    assign o_cfg_ready   = 1'b1;

    ssp_core u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_item_valid (w_accept),
        .i_op         (ssp_pkg::t_op'(s_axis_tuser)),
        .i_step_count (s_axis_tdata),
        .o_result     (w_result)
    );

    ssp_out_skid u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_accept),
        .i_data  (w_result),
        .o_space (w_space),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_data  (w_out)
    );

    assign m_axis_tdata = {{(ssp_pkg::OUT_TDATA_W - $bits(ssp_pkg::t_result)){1'b0}}, w_out};

endmodule
